>>> hdl/idah_pkg.sv
package idah_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CHANGE = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_PRESENT = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_INVALID = 3'd4
  } status_t;

  localparam int unsigned CFG_ARITY     = 0;
  localparam int unsigned CFG_MIN_ORDER = 1;
  localparam logic [31:0] HALF_RANGE    = 32'h8000_0000;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LOOKUP,
    S_DECIDE,
    S_RM_LAST,
    S_RM_LKEY,
    S_RM_CMP,
    S_UP_PARENT,
    S_UP_PKEY,
    S_UP_CMP,
    S_DN_CHILD,
    S_DN_CKEY,
    S_DN_NEXT,
    S_DN_CMP,
    S_PLACE,
    S_TOP_SLOT,
    S_TOP_KEY,
    S_OUT
  } state_t;

  // true when key a belongs above key b
  function automatic logic goes_above(logic [31:0] a, logic [31:0] b, logic min_ord);
    logic [31:0] d;
    begin
      d = min_ord ? (b - a) : (a - b);
      goes_above = (a != b) && (d < HALF_RANGE);
    end
  endfunction

endpackage

>>> hdl/idah_ram.sv
module idah_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hdl/indexed_d_ary_heap.sv
// channel | dir | ports                                   | handshake
// in      | in  | in_cmd, in_item_id, in_key_value         | in_valid / in_ready
// out     | out | out_top_item, out_top_key, out_item_count, out_status | out_valid / out_ready
// cfg     | in  | cfg_we, cfg_index, cfg_data              | write on cfg_we
//
// one word at a time; a command is decided, then lifted (parent, parent key, compare per
// level) or sunk (child, then a key read and best-child pick per child, compare per level)
// and placed; a remove first reads the last item and its key, a rejected or unused command
// goes straight to the top readout; bounded by the one-read-per-cycle slot memory. the position
// map is cleared after reset, one entry a cycle, while in_ready stays low
// the result sits in an output register; a stalled out_ready holds it and
// the next word is taken only once the result has been handed over
module indexed_d_ary_heap #(
  parameter int MAX_ITEMS = 255,
  parameter int MAX_ARITY = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_item_id,
  input  logic [31:0] in_key_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_top_item,
  output logic [31:0] out_top_key,
  output logic [7:0]  out_item_count,
  output logic [2:0]  out_status,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [3:0]  cfg_data
);
  import idah_pkg::*;

  localparam int IW = $clog2(MAX_ITEMS + 1);
  localparam int DEPTH = 1 << IW;
  localparam int AW = $clog2(MAX_ARITY + 1);
  localparam int PW = IW + AW + 1;
  localparam int RS = IW + 6;       // reciprocal scale
  localparam int RW = 2 * IW + 12;  // reciprocal product width

  // configuration
  logic [3:0] arity_r;
  logic       min_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arity_r <= 4'd2;
      min_r   <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == 1'(CFG_ARITY)) arity_r <= cfg_data;
      else min_r <= cfg_data[0];
    end
  end
  logic [AW-1:0] d_eff;
  always_comb begin
    if (arity_r < 4'd2) d_eff = AW'(2);
    else if (32'(arity_r) > MAX_ARITY) d_eff = AW'(MAX_ARITY);
    else d_eff = AW'(arity_r);
  end

  // memories: slot -> item, item -> slot, item -> key
  logic          hs_we, ps_we, ks_we;
  logic [IW-1:0] hs_wa, hs_wd, hs_ra, hs_rd;
  logic [IW-1:0] ps_wa, ps_wd, ps_ra, ps_rd;
  logic [IW-1:0] ks_wa, ks_ra;
  logic [31:0]   ks_wd, ks_rd;

  idah_ram #(.WIDTH(IW), .DEPTH(DEPTH)) u_slots (.clk, .we(hs_we), .waddr(hs_wa),
    .wdata(hs_wd), .raddr(hs_ra), .rdata(hs_rd));
  idah_ram #(.WIDTH(IW), .DEPTH(DEPTH)) u_pos (.clk, .we(ps_we), .waddr(ps_wa),
    .wdata(ps_wd), .raddr(ps_ra), .rdata(ps_rd));
  idah_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_keys (.clk, .we(ks_we), .waddr(ks_wa),
    .wdata(ks_wd), .raddr(ks_ra), .rdata(ks_rd));

  state_t state_r, state_nxt;
  logic          clr_r;
  logic [IW-1:0] clr_idx_r;
  logic [IW:0]   count_r, count_nxt;
  logic [1:0]    cmd_r;
  logic [IW-1:0] id_r, it_r, it_nxt;     // item being placed
  logic [31:0]   key_r, ikey_r, ikey_nxt;  // command key, key of moving item
  logic [IW-1:0] x_r, x_nxt;             // current hole slot
  logic [IW-1:0] px_r, px_nxt;           // parent or best child slot
  logic [IW-1:0] pit_r, pit_nxt;         // item at px
  logic [31:0]   pkey_r, pkey_nxt;       // key at px
  logic [PW-1:0] cy_r, cy_nxt;           // child scan slot
  logic [PW-1:0] clast_r, clast_nxt;
  logic [IW-1:0] cit_r, cit_nxt;
  logic          cfound_r, cfound_nxt;
  logic [2:0]    st_r, st_nxt;
  logic [7:0]    o_item_r, o_cnt_r;
  logic [31:0]   o_key_r;
  logic [2:0]    o_st_r;
  logic [7:0]    o_item_nxt;
  logic [31:0]   o_key_nxt;
  logic          ov_r;

  logic id_bad;
  assign id_bad = (in_item_id == 8'd0) || (32'(in_item_id) > MAX_ITEMS);

  // parent of slot x: (x + d - 2) / d, one reciprocal multiply per arity
  // value, then a small mux on the live arity
  logic [IW-1:0] par_k [2:MAX_ARITY];
  for (genvar k = 2; k <= MAX_ARITY; k++) begin : g_par
    localparam logic [RW-1:0] RM = RW'(((64'd1 << RS) + 64'(k) - 64'd1) / 64'(k));
    logic [RW-1:0] prod;
    assign prod = (RW'(x_r) + RW'(k - 2)) * RM;
    assign par_k[k] = IW'(prod >> RS);
  end

  logic [IW-1:0] parent_x;
  always_comb begin
    parent_x = '0;
    for (int k = 2; k <= MAX_ARITY; k++) begin
      if (32'(d_eff) == k) parent_x = par_k[k];
    end
  end
  logic [PW-1:0] cfirst, clast_c;
  assign cfirst  = PW'(d_eff) * (PW'(x_r) - PW'(1)) + PW'(2);
  assign clast_c = PW'(d_eff) * PW'(x_r) + PW'(1);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    it_nxt = it_r; ikey_nxt = ikey_r; x_nxt = x_r; px_nxt = px_r;
    pit_nxt = pit_r; pkey_nxt = pkey_r; cy_nxt = cy_r; clast_nxt = clast_r;
    cit_nxt = cit_r; cfound_nxt = cfound_r; st_nxt = st_r;
    o_item_nxt = o_item_r; o_key_nxt = o_key_r;
    hs_we = 1'b0; hs_wa = x_r; hs_wd = it_r; hs_ra = x_r;
    ps_we = 1'b0; ps_wa = it_r; ps_wd = x_r; ps_ra = id_r;
    ks_we = 1'b0; ks_wa = id_r; ks_wd = key_r; ks_ra = id_r;
    if (clr_r) begin
      ps_we = 1'b1; ps_wa = clr_idx_r; ps_wd = '0;
    end
    unique case (state_r)
      S_IDLE: begin
        ps_ra = IW'(in_item_id);
        ks_ra = IW'(in_item_id);
        if (in_valid && in_ready) begin
          st_nxt = ST_OK;
          if (in_cmd == CMD_NOP) state_nxt = S_TOP_SLOT;
          else if (id_bad) begin
            st_nxt = ST_INVALID; state_nxt = S_TOP_SLOT;
          end else state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        // ps_rd = position of id, ks_rd = key of id
        hs_ra = IW'(count_r);
        state_nxt = S_TOP_SLOT;
        if (cmd_r == CMD_INSERT) begin
          if (ps_rd != '0) st_nxt = ST_PRESENT;
          else if (32'(count_r) >= MAX_ITEMS) st_nxt = ST_FULL;
          else begin
            ks_we = 1'b1;
            count_nxt = count_r + 1'b1;
            it_nxt = id_r; ikey_nxt = key_r; x_nxt = IW'(count_r + 1'b1);
            state_nxt = S_UP_PARENT;
          end
        end else if (ps_rd == '0) st_nxt = ST_ABSENT;
        else if (cmd_r == CMD_REMOVE) begin
          x_nxt = ps_rd; pkey_nxt = ks_rd;  // hole and removed key
          count_nxt = count_r - 1'b1;
          ps_we = 1'b1; ps_wa = id_r; ps_wd = '0;
          state_nxt = S_RM_LAST;
        end else begin
          ks_we = 1'b1;
          it_nxt = id_r; ikey_nxt = key_r; x_nxt = ps_rd;
          if (key_r == ks_rd) state_nxt = S_TOP_SLOT;
          else if (goes_above(key_r, ks_rd, min_r)) state_nxt = S_UP_PARENT;
          else state_nxt = S_DN_CHILD;
        end
      end
      S_RM_LAST: begin
        // hs_rd = last item
        it_nxt = hs_rd;
        ks_ra = hs_rd;
        if (hs_rd == id_r) state_nxt = S_TOP_SLOT;
        else state_nxt = S_RM_LKEY;
      end
      S_RM_LKEY: begin
        ikey_nxt = ks_rd;
        if (goes_above(ks_rd, pkey_r, min_r) || ks_rd == pkey_r) state_nxt = S_UP_PARENT;
        else state_nxt = S_DN_CHILD;
      end
      S_UP_PARENT: begin
        if (x_r <= IW'(1)) state_nxt = S_PLACE;
        else begin
          px_nxt = parent_x;
          hs_ra = parent_x;
          state_nxt = S_UP_PKEY;
        end
      end
      S_UP_PKEY: begin
        pit_nxt = hs_rd;
        ks_ra = hs_rd;
        state_nxt = S_UP_CMP;
      end
      S_UP_CMP: begin
        if (goes_above(ikey_r, ks_rd, min_r)) begin
          hs_we = 1'b1; hs_wa = x_r; hs_wd = pit_r;
          ps_we = 1'b1; ps_wa = pit_r; ps_wd = x_r;
          x_nxt = px_r;
          state_nxt = S_UP_PARENT;
        end else state_nxt = S_PLACE;
      end
      S_DN_CHILD: begin
        if (cfirst > PW'(count_r)) state_nxt = S_PLACE;
        else begin
          cy_nxt = cfirst;
          clast_nxt = (clast_c > PW'(count_r)) ? PW'(count_r) : clast_c;
          cfound_nxt = 1'b0;
          hs_ra = IW'(cfirst);
          state_nxt = S_DN_CKEY;
        end
      end
      S_DN_CKEY: begin
        cit_nxt = hs_rd;
        ks_ra = hs_rd;
        state_nxt = S_DN_NEXT;
      end
      S_DN_NEXT: begin
        if (!cfound_r || goes_above(ks_rd, pkey_r, min_r)) begin
          cfound_nxt = 1'b1; px_nxt = IW'(cy_r); pit_nxt = cit_r; pkey_nxt = ks_rd;
        end
        if (cy_r < clast_r) begin
          cy_nxt = cy_r + 1'b1;
          hs_ra = IW'(cy_r + 1'b1);
          state_nxt = S_DN_CKEY;
        end else state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (goes_above(pkey_r, ikey_r, min_r)) begin
          hs_we = 1'b1; hs_wa = x_r; hs_wd = pit_r;
          ps_we = 1'b1; ps_wa = pit_r; ps_wd = x_r;
          x_nxt = px_r;
          state_nxt = S_DN_CHILD;
        end else state_nxt = S_PLACE;
      end
      S_PLACE: begin
        hs_we = 1'b1; hs_wa = x_r; hs_wd = it_r;
        ps_we = 1'b1; ps_wa = it_r; ps_wd = x_r;
        state_nxt = S_TOP_SLOT;
      end
      S_TOP_SLOT: begin
        hs_ra = IW'(1);
        state_nxt = S_TOP_KEY;
      end
      S_TOP_KEY: begin
        ks_ra = hs_rd;
        o_item_nxt = 8'(hs_rd);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        o_key_nxt = ks_rd;
        if (count_r == '0) begin
          o_item_nxt = '0; o_key_nxt = '0;
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      clr_r     <= 1'b1;
      clr_idx_r <= '0;
      count_r   <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (clr_r) begin
        clr_idx_r <= clr_idx_r + 1'b1;
        if (clr_idx_r == IW'(DEPTH - 1)) clr_r <= 1'b0;
      end
      if (state_r == S_OUT) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid && in_ready) begin
      cmd_r <= in_cmd;
      id_r  <= IW'(in_item_id);
      key_r <= in_key_value;
    end
    it_r <= it_nxt; ikey_r <= ikey_nxt; x_r <= x_nxt; px_r <= px_nxt;
    pit_r <= pit_nxt; pkey_r <= pkey_nxt; cy_r <= cy_nxt; clast_r <= clast_nxt;
    cit_r <= cit_nxt; cfound_r <= cfound_nxt; st_r <= st_nxt;
    o_item_r <= o_item_nxt; o_key_r <= o_key_nxt;
    if (state_r == S_OUT) begin
      o_cnt_r <= 8'(count_r);
      o_st_r  <= st_r;
    end
  end

  assign in_ready       = (state_r == S_IDLE) && !clr_r && !ov_r;
  assign out_valid      = ov_r;
  assign out_top_item   = o_item_r;
  assign out_top_key    = o_key_r;
  assign out_item_count = o_cnt_r;
  assign out_status     = o_st_r;
endmodule
